// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every sampled edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: lbl");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// File: sv/stbs_pkg.sv
// Shared types and constants of the sorted table search unit.
// No dependencies; used by every module of the block.
package stbs_pkg;

   localparam int POS_W   = 10;
   localparam int INDEX_W = 10;
   localparam int KEYIN_W = 32;
   localparam int COUNT_W = 11;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // item operation codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // register select, word address bit 2
   localparam logic REG_COUNT = 1'b0;
   localparam logic REG_SIGN  = 1'b1;

   typedef struct packed {
      logic store;   // write item: put key in table
      logic load;    // search item: set up range and key
      logic probe;   // read entry at midpoint
      logic narrow;  // shrink range after a mismatch
      logic hit;     // finish with match
      logic miss;    // finish without match
   } stbs_cmd_type;

   typedef struct packed {
      logic empty;   // range holds no entry
      logic equal;   // sought key equals probed entry
      logic less;    // sought key below probed entry
   } stbs_status_type;

endpackage

// File: sv/stbs_ctrl.sv
// Search sequencer: steps probe and check phases of the binary search.
// Depends on stbs_pkg for the command and status structs.
module stbs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_func,
   input  stbs_pkg::stbs_status_type status,
   output stbs_pkg::stbs_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      busy_in    = busy_ff;
      valid_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == stbs_pkg::FUNC_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
                  busy_in  = 1'b1;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.empty) begin
               cmd.miss = 1'b1;
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.equal) begin
               cmd.hit  = 1'b1;
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               cmd.narrow = 1'b1;
               state_in   = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

// File: sv/stbs_dp.sv
// Search datapath: key table memory, range registers, compare and result.
// Depends on stbs_pkg for widths and the command and status structs.
module stbs_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                             clock,
   input  stbs_pkg::stbs_cmd_type           cmd,
   output stbs_pkg::stbs_status_type        status,
   input  logic [stbs_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [stbs_pkg::KEYIN_W-1:0]     req_key,
   input  logic [stbs_pkg::COUNT_W-1:0]     entry_count,
   input  logic                             compare_signed,
   output logic                             rsp_found,
   output logic [stbs_pkg::POS_W-1:0]       rsp_position
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (AW > stbs_pkg::INDEX_W) ? AW : stbs_pkg::INDEX_W;
   localparam int PW = (AW > stbs_pkg::POS_W) ? AW : stbs_pkg::POS_W;
   localparam int XW = (KEY_WIDTH > stbs_pkg::KEYIN_W) ? KEY_WIDTH : stbs_pkg::KEYIN_W;

   logic [KEY_WIDTH-1:0] table_mem [TABLE_DEPTH];

   logic [CW-1:0]        lo_ff, hi_ff;
   logic [AW-1:0]        mid_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] rd_ff;
   logic                 found_ff;
   logic [stbs_pkg::POS_W-1:0] pos_ff;

   logic [IW-1:0]        widx;
   logic                 wr_in_range;
   logic [XW-1:0]        key_x;
   logic [KEY_WIDTH-1:0] key_in;
   logic [31:0]          count_x, count_clamp;
   logic [CW:0]          mid_sum, mid_half;
   logic [AW-1:0]        mid_in;
   logic [KEY_WIDTH-1:0] sign_flip, key_ord, ent_ord;
   logic [PW-1:0]        pos_x;

   assign widx        = IW'(req_entry_index);
   assign wr_in_range = 32'(req_entry_index) < 32'(TABLE_DEPTH);
   assign key_x       = XW'(req_key);
   assign key_in      = key_x[KEY_WIDTH-1:0];

   // entry counts beyond the table are held to its depth
   assign count_x     = 32'(entry_count);
   assign count_clamp = (count_x > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count_x;

   // range is [lo, hi); midpoint rounds down
   assign mid_sum  = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
   assign mid_half = mid_sum >> 1;
   assign mid_in   = mid_half[AW-1:0];

   // signed order by flipping the sign bit, then unsigned compare
   assign sign_flip = {compare_signed, {(KEY_WIDTH-1){1'b0}}};
   assign key_ord   = key_ff ^ sign_flip;
   assign ent_ord   = rd_ff ^ sign_flip;

   assign status.empty = (lo_ff >= hi_ff);
   assign status.equal = (key_ord == ent_ord);
   assign status.less  = (key_ord < ent_ord);

   assign pos_x = PW'(mid_ff);

   always_ff @(posedge clock) begin
      if (cmd.store && wr_in_range) begin
         table_mem[widx[AW-1:0]] <= key_in;
      end
      if (cmd.probe) begin
         rd_ff  <= table_mem[mid_in];
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff  <= '0;
         hi_ff  <= count_clamp[CW-1:0];
         key_ff <= key_in;
      end else if (cmd.narrow) begin
         if (status.less) begin
            hi_ff <= CW'(mid_ff);
         end else begin
            lo_ff <= CW'(mid_ff) + CW'(1);
         end
      end
      if (cmd.hit) begin
         found_ff <= 1'b1;
         pos_ff   <= pos_x[stbs_pkg::POS_W-1:0];
      end else if (cmd.miss) begin
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end
   end

   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule

// File: sv/sorted_table_binary_search_unit.sv
// Channel   Handshake                         Payload
// request   start, busy (taken: start & !busy) req_func, req_entry_index, req_key
// result    rsp_valid, one cycle strobe        rsp_found, rsp_position
// config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// A write item is stored at its accept edge; busy stays low, so the next item
// may follow in the next cycle. A search probes the table in steps: midpoint
// read from the registered table port, then compare. A match ends the search
// from the compare step, and an empty range ends it from the probe step; there
// are at most log2(entry count)+1 probes.
// Reset is synchronous and clears control and config; table contents are kept.
// The result strobe cannot be stalled.
//
// Top level: config registers, sequencer and datapath.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
module sorted_table_binary_search_unit #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [stbs_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [stbs_pkg::KEYIN_W-1:0]   req_key,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [stbs_pkg::POS_W-1:0]     rsp_position,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [stbs_pkg::CSR_AW-1:0]    paddr,
   input  logic [stbs_pkg::CSR_DW-1:0]    pwdata,
   output logic [stbs_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);

   logic [stbs_pkg::COUNT_W-1:0] count_ff;
   logic                         sign_ff;
   logic                         csr_wr;

   stbs_pkg::stbs_cmd_type    cmd;
   stbs_pkg::stbs_status_type status;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   // word decode on address bit 2
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sign_ff  <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2] == stbs_pkg::REG_COUNT) begin
            count_ff <= pwdata[stbs_pkg::COUNT_W-1:0];
         end else begin
            sign_ff <= pwdata[0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == stbs_pkg::REG_COUNT) begin
         prdata = stbs_pkg::CSR_DW'(count_ff);
      end else begin
         prdata = stbs_pkg::CSR_DW'(sign_ff);
      end
   end

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_key         (req_key),
      .entry_count     (count_ff),
      .compare_signed  (sign_ff),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule

// File: sv/stbs_checker.sv
// Port-level checks on the search unit, bound to the top level.
// Depends on assert_macros.svh and stbs_pkg.
`include "assert_macros.svh"

module stbs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_func,
   input logic                         rsp_valid,
   input logic                         rsp_found,
   input logic [stbs_pkg::POS_W-1:0]   rsp_position
);

   // a search item always occupies the block for a while
   `ASSERT_NEXT(search_goes_busy, clock, reset,
      start && !busy && (req_func == stbs_pkg::FUNC_SEARCH), busy)

   // a miss reports position zero
   `ASSERT_SAME(miss_pos_zero, clock, reset, rsp_valid && !rsp_found, rsp_position == '0)

   // strobe lasts one cycle
   `ASSERT_NEXT(strobe_single, clock, reset, rsp_valid, !rsp_valid)

   // a result only ends a busy spell
   `ASSERT_SAME(result_after_busy, clock, reset, rsp_valid, $past(busy) && !busy)

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);

// File: tb/tb_sorted_table_binary_search_unit.sv
// Self-checking bench for sorted_table_binary_search_unit: table loads, searches,
// count and key-order register changes, with random gaps on the request side.
// Depends on stbs_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_sorted_table_binary_search_unit;

   localparam int DEPTH     = 1024;
   localparam int TAIL      = 30;
   localparam int LIMIT     = 400000;
   localparam int RAND_OPS  = 540;
   localparam logic [stbs_pkg::CSR_AW-1:0] CNT_ADDR  = {stbs_pkg::REG_COUNT, 2'b00};
   localparam logic [stbs_pkg::CSR_AW-1:0] SIGN_ADDR = {stbs_pkg::REG_SIGN, 2'b00};

   typedef struct packed {
      logic                         func;
      logic [stbs_pkg::INDEX_W-1:0] idx;
      logic [stbs_pkg::KEYIN_W-1:0] key;
   } table_op_type;

   typedef struct packed {
      logic                       found;
      logic [stbs_pkg::POS_W-1:0] position;
   } match_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_func = stbs_pkg::FUNC_WRITE;
   logic [stbs_pkg::INDEX_W-1:0] req_entry_index = '0;
   logic [stbs_pkg::KEYIN_W-1:0] req_key = '0;
   logic                         rsp_valid;
   logic                         rsp_found;
   logic [stbs_pkg::POS_W-1:0]   rsp_position;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [stbs_pkg::CSR_AW-1:0]  paddr = '0;
   logic [stbs_pkg::CSR_DW-1:0]  pwdata = '0;
   logic [stbs_pkg::CSR_DW-1:0]  prdata;
   logic                         pready;

   // predictor state
   logic [stbs_pkg::KEYIN_W-1:0] key_tbl [DEPTH];
   logic [stbs_pkg::COUNT_W-1:0] cfg_count = '0;
   logic                         cfg_signed = 1'b0;

   // stimulus planning copy of the table, updated as items are queued
   logic [stbs_pkg::KEYIN_W-1:0] staged [DEPTH];

   table_op_type op_queue [$];
   match_type    pending_matches [$];
   int           spine_idx [$];
   int           queued = 0;
   int           accepted = 0;
   int           errors = 0;
   int           cycles = 0;
   logic         steady = 1'b0;

   sorted_table_binary_search_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   function automatic logic key_below(logic [stbs_pkg::KEYIN_W-1:0] a,
                                      logic [stbs_pkg::KEYIN_W-1:0] b);
      if (cfg_signed) return $signed(a) < $signed(b);
      return a < b;
   endfunction

   function automatic match_type search_table(logic [stbs_pkg::KEYIN_W-1:0] key);
      match_type m;
      int        lo;
      int        hi;
      int        mid;
      logic      done;
      m = '0;
      done = 1'b0;
      lo = 0;
      hi = ((cfg_count > DEPTH) ? DEPTH : int'(cfg_count)) - 1;
      while (!done && lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (key == key_tbl[mid]) begin
            m.found = 1'b1;
            m.position = mid[stbs_pkg::POS_W-1:0];
            done = 1'b1;
         end else if (key_below(key, key_tbl[mid])) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return m;
   endfunction

   task automatic push_write(int idx, logic [stbs_pkg::KEYIN_W-1:0] key);
      op_queue.push_back('{stbs_pkg::FUNC_WRITE, idx[stbs_pkg::INDEX_W-1:0], key});
      staged[idx] = key;
      queued++;
   endtask

   task automatic push_search(logic [stbs_pkg::KEYIN_W-1:0] key);
      int unsigned                  r;
      logic [stbs_pkg::INDEX_W-1:0] junk;
      r = $urandom;
      junk = r[stbs_pkg::INDEX_W-1:0];
      op_queue.push_back('{stbs_pkg::FUNC_SEARCH, junk, key});
      queued++;
   endtask

   // entries 0..n-1 ascending in the chosen order, with the odd duplicate
   task automatic load_sorted(int n, logic signed_order);
      longint unsigned step;
      longint unsigned k;
      logic [stbs_pkg::KEYIN_W-1:0] prev;
      logic [stbs_pkg::KEYIN_W-1:0] key;
      step = 64'h1_0000_0000 / n;
      prev = '0;
      for (int i = 0; i < n; i++) begin
         k = i * step + {$urandom, $urandom} % step;
         key = k[stbs_pkg::KEYIN_W-1:0];
         if (i > 0 && $urandom_range(0, 19) == 0) key = prev;
         prev = key;
         push_write(i, signed_order ? key ^ 32'h8000_0000 : key);
      end
   endtask

   // ascending with the index, so spine entries stay in order
   function automatic logic [stbs_pkg::KEYIN_W-1:0] spine_key(int idx);
      return {idx[stbs_pkg::INDEX_W-1:0], 22'h15555};
   endfunction

   // only the midpoints a search meets when it keeps going one way
   task automatic load_spine();
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = DEPTH;
      while (lo < hi) begin
         mid = (lo + hi - 1) / 2;
         spine_idx.push_back(mid);
         push_write(mid, spine_key(mid));
         lo = mid + 1;
      end
      lo = 0;
      hi = DEPTH;
      while (lo < hi) begin
         mid = (lo + hi - 1) / 2;
         spine_idx.push_back(mid);
         push_write(mid, spine_key(mid));
         hi = mid;
      end
   endtask

   // keys on the spine, below every spine entry and above every spine entry
   task automatic spine_searches();
      foreach (spine_idx[i]) push_search(spine_key(spine_idx[i]));
      push_search(32'h0000_0000);
      push_search(32'hFFFF_FFFF);
   endtask

   function automatic logic [stbs_pkg::KEYIN_W-1:0] pick_key(int n);
      int r;
      r = $urandom_range(0, 9);
      if (n > 0 && r < 6) return staged[$urandom_range(0, n - 1)];
      if (n > 0 && r < 8)
         return staged[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      return $urandom;
   endfunction

   task automatic csr_write(logic [stbs_pkg::CSR_AW-1:0] addr,
                            logic [stbs_pkg::CSR_DW-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == CNT_ADDR) cfg_count = data[stbs_pkg::COUNT_W-1:0];
      else cfg_signed = data[0];
   endtask

   // sender holds off until everything queued is taken and answered
   task automatic wait_idle();
      while (op_queue.size() != 0 || accepted != queued || pending_matches.size() != 0)
         @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic search_phase(int n, int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) push_write($urandom_range(0, DEPTH - 1), $urandom);
         push_search(pick_key(n));
      end
      wait_idle();
   endtask

   // request driver
   always @(posedge clock) begin : drive
      table_op_type op;
      logic         next_start;
      next_start = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            if (req_func == stbs_pkg::FUNC_WRITE) key_tbl[req_entry_index] = req_key;
            else pending_matches.push_back(search_table(req_key));
            accepted++;
         end
         if (start && busy) begin
            next_start = 1'b1;
         end else if (op_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
            op = op_queue.pop_front();
            req_func <= op.func;
            req_entry_index <= op.idx;
            req_key <= op.key;
            next_start = 1'b1;
         end
      end
      start <= next_start;
   end

   // result checker and run limit
   always @(posedge clock) begin : check
      match_type want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (pending_matches.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: found=%0b position=%0d",
                     $time, rsp_found, rsp_position);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_found !== want.found) begin
               errors++;
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
            end
            if (rsp_position !== want.position) begin
               errors++;
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp_position);
            end
         end
      end
   end

   initial begin
      int base;
      int phase;
      int cnt;
      int n;
      int r;
      logic sgn;
      for (int i = 0; i < DEPTH; i++) begin
         key_tbl[i] = '0;
         staged[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table
      push_search(32'h0000_0000);
      push_search(32'hFFFF_FFFF);
      push_write(0, 32'h0000_0005);
      push_write(1, 32'h7FFF_FFFF);
      push_write(2, 32'h8000_0000);
      push_write(3, 32'hFFFF_FFFF);
      push_write(1023, 32'hA5A5_A5A5);
      push_write(512, 32'h0000_0000);
      wait_idle();
      csr_write(CNT_ADDR, 4);
      csr_write(SIGN_ADDR, 0);
      push_search(32'h0000_0005);
      push_search(32'h7FFF_FFFF);
      push_search(32'h8000_0000);
      push_search(32'hFFFF_FFFF);
      push_search(32'h0000_0000);
      push_search(32'h0000_0006);
      wait_idle();
      // same table read in signed order is no longer sorted
      csr_write(SIGN_ADDR, {31'h7FFF_FFFF, 1'b1});
      push_search(32'h8000_0000);
      push_search(32'hFFFF_FFFF);
      push_search(32'h0000_0005);
      wait_idle();
      csr_write(CNT_ADDR, 1);
      push_search(32'h0000_0005);
      push_search(32'h0000_0004);
      wait_idle();

      // full depth, unsigned order, spine entries only
      csr_write(SIGN_ADDR, 0);
      load_spine();
      wait_idle();
      csr_write(CNT_ADDR, DEPTH);
      spine_searches();
      wait_idle();
      // count above depth, junk in the upper data bits
      csr_write(CNT_ADDR, ($urandom & 32'hFFFF_F800) | 32'h0000_07FF);
      spine_searches();
      wait_idle();

      base = queued;
      phase = 0;
      while (queued - base < RAND_OPS) begin
         sgn = ($urandom_range(0, 1) == 1);
         r = $urandom_range(0, 9);
         if (r == 0) cnt = 0;
         else if (r == 1) cnt = 1;
         else if (r == 2) cnt = 2;
         else cnt = $urandom_range(3, 64);
         n = cnt;
         steady = (phase == 2);
         if (n > 0) load_sorted(n, sgn);
         wait_idle();
         csr_write(CNT_ADDR, cnt);
         csr_write(SIGN_ADDR, 32'(sgn));
         search_phase(n, $urandom_range(15, 35));
         phase++;
      end
      steady = 1'b0;
      wait_idle();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
